// ===== hw/rtl/olst_pkg.sv =====
// Package for the ordered list engine: request codes, state encoding and
// field widths shared by the engine and its port checker.
// No dependencies.
package olst_pkg;

	localparam int FUNC_W = 3;
	localparam int DATA_W = 32;

	// Request codes carried on func
	localparam logic [FUNC_W-1:0] FN_INS_HEAD = 3'd0;
	localparam logic [FUNC_W-1:0] FN_INS_TAIL = 3'd1;
	localparam logic [FUNC_W-1:0] FN_INS_ORD  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_REM_HEAD = 3'd3;
	localparam logic [FUNC_W-1:0] FN_REM_VAL  = 3'd4;
	localparam logic [FUNC_W-1:0] FN_MEMBER   = 3'd5;

	// Sequencer states, one-hot
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_SHUP = 5'b00100,
		ST_WRV  = 5'b01000,
		ST_SHDN = 5'b10000
	} state_t;

endpackage

// ===== hw/rtl/ordered_list_engine.sv =====
// Done rises in the cycle after start for a full/empty reject or an unused code; otherwise
// the request runs through the scan and shift states: the scan stops at the hit and the
// shift covers only the entries at or past it, one entry per cycle each through the single read
// and single write port.
// Throughput: one request at a time; start is taken whenever busy is low, including the
// cycle in which done shows the previous result. The receiver cannot stall.
// Reset (arst_n, async, active low) empties the list; the entry memory is not cleared.
//
// Ordered list engine: list store in a 1R1W memory plus count and a small sequencer.
// Depends on olst_pkg.
module ordered_list_engine #(
	parameter int DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [olst_pkg::FUNC_W-1:0]         func,
	input  logic signed [olst_pkg::DATA_W-1:0]  value,
	output logic                                done,
	output logic                                ok,
	output logic signed [olst_pkg::DATA_W-1:0]  out_value,
	output logic [$clog2(DEPTH+1)-1:0]          count
);
	import olst_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// Entry store, index 0 is the head
	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic [AW-1:0]     rd_addr;
	logic              we;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;

	// Control state
	state_t            state_q, state_d;
	logic [CW-1:0]     occ_q, occ_d;
	logic [CW-1:0]     cmp_q, cmp_d;      // index whose data sits in rd_data_q during scan
	logic [CW-1:0]     src_q, src_d;      // index whose data sits in rd_data_q during shifts
	logic [CW-1:0]     pos_q, pos_d;      // insert or remove position
	logic [FUNC_W-1:0] func_q;
	logic [DATA_W-1:0] value_q;
	logic [DATA_W-1:0] head_q, head_d;    // value taken by remove head

	// Result beat
	logic              done_q;
	logic              ok_q;
	logic [DATA_W-1:0] oval_q;
	logic [CW-1:0]     cnt_q;

	logic              fin;
	logic              fin_ok;
	logic [DATA_W-1:0] fin_val;
	logic              full;
	logic              accept;
	logic              hit;
	logic [CW-1:0]     occ_m1;
	logic [CW-1:0]     cmp_p1;

	assign accept = start && (state_q == ST_IDLE);
	assign full   = (occ_q == CW'(DEPTH));
	assign occ_m1 = occ_q - 1'b1;
	assign cmp_p1 = cmp_q + 1'b1;

	// Match test on the entry read back during the scan
	always_comb begin
		unique case (func_q)
			FN_INS_ORD:  hit = ($signed(rd_data_q) >= $signed(value_q));
			FN_REM_HEAD: hit = 1'b1;
			FN_REM_VAL:  hit = (rd_data_q == value_q);
			FN_MEMBER:   hit = (rd_data_q == value_q);
			default:     hit = 1'b0;
		endcase
	end

	// Sequencer
	always_comb begin
		state_d = state_q;
		occ_d   = occ_q;
		cmp_d   = cmp_q;
		src_d   = src_q;
		pos_d   = pos_q;
		head_d  = head_q;
		rd_addr = '0;
		we      = 1'b0;
		wr_addr = pos_q[AW-1:0];
		wr_data = value_q;
		fin     = 1'b0;
		fin_ok  = 1'b0;
		fin_val = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (func)
						FN_INS_HEAD: begin
							pos_d = '0;
							if (full) begin
								fin = 1'b1;
							end else if (occ_q == '0) begin
								state_d = ST_WRV;
							end else begin
								rd_addr = occ_m1[AW-1:0];
								src_d   = occ_m1;
								state_d = ST_SHUP;
							end
						end
						FN_INS_TAIL: begin
							pos_d = occ_q;
							if (full) fin = 1'b1;
							else state_d = ST_WRV;
						end
						FN_INS_ORD: begin
							pos_d = '0;
							cmp_d = '0;
							if (full) begin
								fin = 1'b1;
							end else if (occ_q == '0) begin
								state_d = ST_WRV;
							end else begin
								state_d = ST_SCAN;
							end
						end
						FN_REM_HEAD, FN_REM_VAL, FN_MEMBER: begin
							cmp_d = '0;
							if (occ_q == '0) fin = 1'b1;
							else state_d = ST_SCAN;
						end
						default: fin = 1'b1;
					endcase
				end
			end

			// One entry compared per cycle, next read issued in parallel
			ST_SCAN: begin
				if (hit) begin
					pos_d = cmp_q;
					priority if (func_q == FN_INS_ORD) begin
						rd_addr = occ_m1[AW-1:0];
						src_d   = occ_m1;
						state_d = ST_SHUP;
					end else if (func_q == FN_MEMBER) begin
						fin    = 1'b1;
						fin_ok = 1'b1;
					end else begin
						// remove head or remove value
						if (func_q == FN_REM_HEAD) head_d = rd_data_q;
						if (cmp_q == occ_m1) begin
							fin    = 1'b1;
							fin_ok = 1'b1;
							occ_d  = occ_m1;
							if (func_q == FN_REM_HEAD) fin_val = rd_data_q;
						end else begin
							rd_addr = cmp_p1[AW-1:0];
							src_d   = cmp_p1;
							state_d = ST_SHDN;
						end
					end
				end else if (cmp_p1 == occ_q) begin
					if (func_q == FN_INS_ORD) begin
						pos_d   = occ_q;
						state_d = ST_WRV;
					end else begin
						fin = 1'b1;
					end
				end else begin
					cmp_d   = cmp_p1;
					rd_addr = cmp_p1[AW-1:0];
				end
			end

			// Move entries up by one, from the tail down to the insert position
			ST_SHUP: begin
				we      = 1'b1;
				wr_addr = AW'(src_q + 1'b1);
				wr_data = rd_data_q;
				if (src_q == pos_q) begin
					state_d = ST_WRV;
				end else begin
					rd_addr = AW'(src_q - 1'b1);
					src_d   = src_q - 1'b1;
				end
			end

			// Write the new value in place
			ST_WRV: begin
				we     = 1'b1;
				fin    = 1'b1;
				fin_ok = 1'b1;
				occ_d  = occ_q + 1'b1;
			end

			// Move entries down by one over the removed slot
			ST_SHDN: begin
				we      = 1'b1;
				wr_addr = AW'(src_q - 1'b1);
				wr_data = rd_data_q;
				if (src_q == occ_m1) begin
					fin    = 1'b1;
					fin_ok = 1'b1;
					occ_d  = occ_m1;
					if (func_q == FN_REM_HEAD) fin_val = head_q;
				end else begin
					rd_addr = AW'(src_q + 1'b1);
					src_d   = src_q + 1'b1;
				end
			end

			default: state_d = ST_IDLE;
		endcase

		if (fin) state_d = ST_IDLE;
	end

	// Entry memory, read data registered
	always_ff @(posedge clk) begin
		if (we) mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			occ_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			done_q  <= fin;
		end
	end

	// Request and working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			value_q <= value;
		end
		cmp_q  <= cmp_d;
		src_q  <= src_d;
		pos_q  <= pos_d;
		head_q <= head_d;
		if (fin) begin
			ok_q   <= fin_ok;
			oval_q <= fin_val;
			cnt_q  <= occ_d;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign ok        = ok_q;
	assign out_value = oval_q;
	assign count     = cnt_q;

endmodule

// ===== hw/rtl/olst_chk.sv =====
// Port-level checker for the ordered list engine, bound into every ordered_list_engine instance.
// Depends on olst_pkg and ordered_list_engine.
module olst_chk #(
	parameter int DEPTH = 64
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic [olst_pkg::FUNC_W-1:0]         func,
	input logic signed [olst_pkg::DATA_W-1:0]  value,
	input logic                                done,
	input logic                                ok,
	input logic signed [olst_pkg::DATA_W-1:0]  out_value,
	input logic [$clog2(DEPTH+1)-1:0]          count
);
	import olst_pkg::*;

	// A taken request either keeps the engine busy or answers next cycle
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("request neither started work nor answered");

	// Every result beat follows a request or ongoing work
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("result beat without a request");

	// Failed requests return a zero value
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ok |-> out_value == '0)
		else $error("nonzero value on a failed request");

	// Count never exceeds the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> count <= ($clog2(DEPTH+1))'(DEPTH))
		else $error("count beyond depth");

	// Unused request codes never succeed
	a_unused_fail: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && func != FN_INS_HEAD && func != FN_INS_TAIL &&
		func != FN_INS_ORD && func != FN_REM_HEAD && func != FN_REM_VAL &&
		func != FN_MEMBER |=> done && !ok)
		else $error("unused code reported success");

endmodule

bind ordered_list_engine olst_chk #(.DEPTH(DEPTH)) u_olst_chk (.*);
